### hw/rtl/mpet_pkg.sv
// ============================================================================
// mpet_pkg - shared types and constants for the min-priority entry table
// Action and status codes, controller states and the command/status
// structs that pass between the controller and the datapath.
// ============================================================================
package mpet_pkg;

    localparam int ACTION_W        = 2;
    localparam int STATUS_W        = 2;
    localparam int ID_W            = 31;
    localparam int IN_LEVEL_W      = 4;
    localparam int COUNT_OUT_W     = 6;
    localparam int DEF_TABLE_DEPTH = 32;
    localparam int DEF_LEVEL_BITS  = 4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_PEEK   = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_FULL      = 2'd1,
        STS_NOT_FOUND = 2'd2,
        STS_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_EXEC   = 3'd1,
        ST_SCAN   = 3'd2,
        ST_DRAIN  = 3'd3,
        ST_OUTPUT = 3'd4
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic scan_issue;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_needed;
        logic last_issue;
        logic out_free;
    } dp_sts_t;

endpackage

### hw/rtl/mpet_req_if.sv
// ============================================================================
// mpet_req_if - request channel of the min-priority entry table
// Valid/ready handshake carrying one action beat.
// ============================================================================
interface mpet_req_if;
    logic                              valid;
    logic                              ready;
    logic [mpet_pkg::ACTION_W-1:0]     action;
    logic [mpet_pkg::ID_W-1:0]         entry_id;
    logic [mpet_pkg::IN_LEVEL_W-1:0]   entry_level;

    modport source (output valid, action, entry_id, entry_level, input ready);
    modport sink   (input valid, action, entry_id, entry_level, output ready);
endinterface

### hw/rtl/mpet_rsp_if.sv
// ============================================================================
// mpet_rsp_if - response channel of the min-priority entry table
// Valid/ready handshake carrying one result beat.
// ============================================================================
interface mpet_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [mpet_pkg::STATUS_W-1:0]     status;
    logic [mpet_pkg::ID_W-1:0]         next_id;
    logic [mpet_pkg::IN_LEVEL_W-1:0]   next_level;
    logic [mpet_pkg::COUNT_OUT_W-1:0]  entry_count;

    modport source (output valid, status, next_id, next_level, entry_count, input ready);
    modport sink   (input valid, status, next_id, next_level, entry_count, output ready);
endinterface

### hw/rtl/mpet_ctrl.sv
// ============================================================================
// mpet_ctrl - sequencer of the min-priority entry table
// Steps each action through execute, table walk and result hand-off.
// ============================================================================
module mpet_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  mpet_pkg::dp_sts_t sts,
    output mpet_pkg::dp_cmd_t cmd
);

    mpet_pkg::state_t state_reg;
    mpet_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mpet_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mpet_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = mpet_pkg::ST_EXEC;
                end
            end
            mpet_pkg::ST_EXEC:
            begin
                state_next = sts.scan_needed ? mpet_pkg::ST_SCAN : mpet_pkg::ST_OUTPUT;
            end
            mpet_pkg::ST_SCAN:
            begin
                if (sts.last_issue)
                begin
                    state_next = mpet_pkg::ST_DRAIN;
                end
            end
            mpet_pkg::ST_DRAIN:
            begin
                state_next = mpet_pkg::ST_OUTPUT;
            end
            mpet_pkg::ST_OUTPUT:
            begin
                if (sts.out_free)
                begin
                    state_next = mpet_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mpet_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready      = 1'b0;
        cmd.capture    = 1'b0;
        cmd.exec       = 1'b0;
        cmd.scan_issue = 1'b0;
        cmd.load_out   = 1'b0;
        unique case (state_reg)
            mpet_pkg::ST_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            mpet_pkg::ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            mpet_pkg::ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
            end
            mpet_pkg::ST_DRAIN:
            begin
                cmd.load_out = 1'b0;
            end
            mpet_pkg::ST_OUTPUT:
            begin
                cmd.load_out = sts.out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // walk ends only after the last read was issued
    a_drain_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mpet_pkg::ST_DRAIN) |-> $past(sts.last_issue))
        else $error("drain entered without final read");

    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (state_reg == mpet_pkg::ST_OUTPUT) && sts.out_free)
        else $error("result loaded while output held");

endmodule

### hw/rtl/mpet_dp.sv
// ============================================================================
// mpet_dp - datapath of the min-priority entry table
// Entry memory, walk pointer, compare stage, lowest-level tracking and
// the result register.
// ============================================================================
module mpet_dp #(
    parameter int TABLE_DEPTH = mpet_pkg::DEF_TABLE_DEPTH,
    parameter int LEVEL_BITS  = mpet_pkg::DEF_LEVEL_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mpet_pkg::dp_cmd_t                 cmd,
    output mpet_pkg::dp_sts_t                 sts,
    input  logic [mpet_pkg::ACTION_W-1:0]     req_action,
    input  logic [mpet_pkg::ID_W-1:0]         req_id,
    input  logic [mpet_pkg::IN_LEVEL_W-1:0]   req_level,
    input  logic                              rsp_ready,
    output logic                              rsp_valid,
    output logic [mpet_pkg::STATUS_W-1:0]     rsp_status,
    output logic [mpet_pkg::ID_W-1:0]         rsp_next_id,
    output logic [mpet_pkg::IN_LEVEL_W-1:0]   rsp_next_level,
    output logic [mpet_pkg::COUNT_OUT_W-1:0]  rsp_entry_count
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int ENT_W = mpet_pkg::ID_W + LEVEL_BITS;

    logic [ENT_W-1:0] mem [TABLE_DEPTH];

    mpet_pkg::action_t         act_reg;
    mpet_pkg::status_t         status_reg;
    logic [mpet_pkg::ID_W-1:0] id_reg;
    logic [LEVEL_BITS-1:0]     lvl_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          ptr_reg;
    logic                      cmp_valid_reg;
    logic [IDX_W-1:0]          cmp_idx_reg;
    logic [ENT_W-1:0]          rd_data_reg;
    logic                      found_reg;
    logic [mpet_pkg::ID_W-1:0] best_id_reg;
    logic [LEVEL_BITS-1:0]     best_lvl_reg;

    logic                                 out_valid_reg;
    mpet_pkg::status_t                    out_status_reg;
    logic [mpet_pkg::ID_W-1:0]            out_id_reg;
    logic [mpet_pkg::IN_LEVEL_W-1:0]      out_lvl_reg;
    logic [mpet_pkg::COUNT_OUT_W-1:0]     out_count_reg;

    logic [mpet_pkg::IN_LEVEL_W+LEVEL_BITS-1:0]  lvl_in_ext;
    logic [mpet_pkg::IN_LEVEL_W+LEVEL_BITS-1:0]  lvl_out_ext;
    logic [mpet_pkg::COUNT_OUT_W+CNT_W-1:0]      count_out_ext;

    logic [mpet_pkg::ID_W-1:0] rd_id;
    logic [LEVEL_BITS-1:0]     rd_lvl;
    logic                      is_full;
    logic                      ins_ok;
    logic                      shift_wr;
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;
    logic [ENT_W-1:0]          wr_data;
    logic                      remove_hit;
    logic                      peek_ok;
    mpet_pkg::status_t         fin_status;
    logic [CNT_W-1:0]          fin_count;
    logic                      out_free;

    assign lvl_in_ext = {{LEVEL_BITS{1'b0}}, req_level};
    assign rd_id      = rd_data_reg[ENT_W-1:LEVEL_BITS];
    assign rd_lvl     = rd_data_reg[LEVEL_BITS-1:0];

    assign is_full  = (count_reg == CNT_W'(TABLE_DEPTH));
    assign ins_ok   = cmd.exec && (act_reg == mpet_pkg::ACT_INSERT) && !is_full;
    // once the match is behind us, every later entry moves down one slot
    assign shift_wr = cmp_valid_reg && (act_reg == mpet_pkg::ACT_REMOVE) && found_reg;
    assign wr_en    = ins_ok || shift_wr;
    assign wr_addr  = shift_wr ? (cmp_idx_reg - IDX_W'(1)) : count_reg[IDX_W-1:0];
    assign wr_data  = shift_wr ? rd_data_reg : {id_reg, lvl_reg};

    assign remove_hit = (act_reg == mpet_pkg::ACT_REMOVE) && (status_reg == mpet_pkg::STS_OK)
                        && found_reg;
    assign peek_ok    = (act_reg == mpet_pkg::ACT_PEEK) && (status_reg == mpet_pkg::STS_OK);
    assign fin_status = ((act_reg == mpet_pkg::ACT_REMOVE) && (status_reg == mpet_pkg::STS_OK)
                         && !found_reg) ? mpet_pkg::STS_NOT_FOUND : status_reg;
    assign fin_count  = remove_hit ? (count_reg - CNT_W'(1)) : count_reg;

    assign lvl_out_ext   = {{mpet_pkg::IN_LEVEL_W{1'b0}}, best_lvl_reg};
    assign count_out_ext = {{mpet_pkg::COUNT_OUT_W{1'b0}}, fin_count};

    assign out_free        = !out_valid_reg || rsp_ready;
    assign sts.out_free    = out_free;
    assign sts.scan_needed = ((act_reg == mpet_pkg::ACT_REMOVE) ||
                              (act_reg == mpet_pkg::ACT_PEEK)) && (count_reg != '0);
    assign sts.last_issue  = (CNT_W'(ptr_reg + CNT_W'(1)) == count_reg);

    // entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.scan_issue)
        begin
            rd_data_reg <= mem[ptr_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= cmd.scan_issue;
            if (cmd.exec)
            begin
                ptr_reg   <= '0;
                found_reg <= 1'b0;
                if (ins_ok)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                else if (act_reg == mpet_pkg::ACT_CLEAR)
                begin
                    count_reg <= '0;
                end
            end
            if (cmd.scan_issue)
            begin
                ptr_reg <= ptr_reg + CNT_W'(1);
            end
            if (cmp_valid_reg)
            begin
                if ((act_reg == mpet_pkg::ACT_REMOVE) && !found_reg && (rd_id == id_reg))
                begin
                    found_reg <= 1'b1;
                end
                if ((act_reg == mpet_pkg::ACT_PEEK) && (!found_reg || (rd_lvl < best_lvl_reg)))
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.load_out)
            begin
                count_reg     <= fin_count;
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= mpet_pkg::action_t'(req_action);
            id_reg  <= req_id;
            lvl_reg <= lvl_in_ext[LEVEL_BITS-1:0];
        end
        if (cmd.exec)
        begin
            case (act_reg) inside
                mpet_pkg::ACT_INSERT:
                begin
                    status_reg <= is_full ? mpet_pkg::STS_FULL : mpet_pkg::STS_OK;
                end
                mpet_pkg::ACT_REMOVE, mpet_pkg::ACT_PEEK:
                begin
                    status_reg <= (count_reg == '0) ? mpet_pkg::STS_EMPTY : mpet_pkg::STS_OK;
                end
                default:
                begin
                    status_reg <= mpet_pkg::STS_OK;
                end
            endcase
        end
        if (cmd.scan_issue)
        begin
            cmp_idx_reg <= ptr_reg[IDX_W-1:0];
        end
        // strict compare keeps the earliest entry on a tie
        if (cmp_valid_reg && (act_reg == mpet_pkg::ACT_PEEK)
            && (!found_reg || (rd_lvl < best_lvl_reg)))
        begin
            best_id_reg  <= rd_id;
            best_lvl_reg <= rd_lvl;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= fin_status;
            out_id_reg     <= peek_ok ? best_id_reg : '0;
            out_lvl_reg    <= peek_ok ? lvl_out_ext[mpet_pkg::IN_LEVEL_W-1:0] : '0;
            out_count_reg  <= count_out_ext[mpet_pkg::COUNT_OUT_W-1:0];
        end
    end

    assign rsp_valid       = out_valid_reg;
    assign rsp_status      = out_status_reg;
    assign rsp_next_id     = out_id_reg;
    assign rsp_next_level  = out_lvl_reg;
    assign rsp_entry_count = out_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_shift_not_head: assert property (@(posedge clk) disable iff (!rst_n)
        shift_wr |-> (cmp_idx_reg != '0))
        else $error("compaction write below slot zero");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_issue |-> (ptr_reg < count_reg))
        else $error("walk read past last entry");

endmodule

### hw/rtl/min_priority_entry_table_core.sv
// ============================================================================
// min_priority_entry_table_core - bounded entry table with lowest-level peek
// Insert, clear and any action on an empty table go from execute straight to
// the result register; remove and peek on a held table first walk every held
// entry through the read port, one entry per cycle. A new request is taken
// only once the previous result has been loaded into the output register.
// Reset clears the entry count and handshake state; table contents are kept.
// ============================================================================
module min_priority_entry_table_core #(
    parameter int TABLE_DEPTH = mpet_pkg::DEF_TABLE_DEPTH,
    parameter int LEVEL_BITS  = mpet_pkg::DEF_LEVEL_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    mpet_req_if.sink   req,
    mpet_rsp_if.source rsp
);

    mpet_pkg::dp_cmd_t cmd;
    mpet_pkg::dp_sts_t sts;

    mpet_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    mpet_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .LEVEL_BITS  (LEVEL_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .req_action      (req.action),
        .req_id          (req.entry_id),
        .req_level       (req.entry_level),
        .rsp_ready       (rsp.ready),
        .rsp_valid       (rsp.valid),
        .rsp_status      (rsp.status),
        .rsp_next_id     (rsp.next_id),
        .rsp_next_level  (rsp.next_level),
        .rsp_entry_count (rsp.entry_count)
    );

endmodule
